[sv/rgbyuv_pkg.sv]
// shared types and constants for the rgb to yuv 4:2:0 converter
// no dependencies; used by rgbyuv_csc and rgb_to_yuv420_converter_top

package rgbyuv_pkg;

    localparam int LEVEL_W = 10;   // unsigned q2.8 input component
    localparam int PIX_W   = 8;    // output byte
    localparam int DIM_W   = 13;   // frame dimension register width

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } rgb_t;

    // position flags of one pixel, taken from the column and row counters
    typedef struct packed {
        logic chroma_valid;
        logic chroma_plane;
        logic frame_end;
    } pos_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma;
        pos_t             pos;
    } yuv_t;

endpackage

[sv/rgb_to_yuv420_converter_top.sv]
// rgb to yuv 4:2:0 converter, one pixel per transaction in raster order
// registered path from input transaction to result: input stage, then result register
// throughput: one pixel per clock; the result register frees the input side while
// a result waits, so a stall on the output only holds the input once both stages fill
// reset: synchronous active-low aresetn clears counters, valids and sets 1920x1080
// depends on rgbyuv_pkg and rgbyuv_csc

module rgb_to_yuv420_converter_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red_level[9:0], green_level[19:10], blue_level[29:20]
    // yuv output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // luma[7:0], chroma[15:8]
    output logic [1:0]  m_tuser,   // chroma_valid[0], chroma_plane[1]
    output logic        m_tlast    // frame_end
);

    localparam int CW = $clog2(MAX_DIM);
    // wide enough for both the register value and MAX_DIM itself
    localparam int EW = (CW + 1 > rgbyuv_pkg::DIM_W) ? CW + 1 : rgbyuv_pkg::DIM_W;

    // configuration
    logic [rgbyuv_pkg::DIM_W-1:0] width_reg, height_reg;

    // position counters
    logic [CW-1:0] col_reg, row_reg;
    logic [CW-1:0] col_next, row_next;

    // input stage
    logic             s1_valid_reg;
    rgbyuv_pkg::rgb_t s1_pix_reg;
    rgbyuv_pkg::pos_t s1_pos_reg;

    // result register
    logic             m_valid_reg;
    rgbyuv_pkg::yuv_t m_res_reg;

    rgbyuv_pkg::rgb_t in_pix;
    rgbyuv_pkg::pos_t in_pos;
    rgbyuv_pkg::yuv_t csc_res;

    logic          s1_adv;     // input stage may move into the result register
    logic          s_acc;      // input transaction this cycle
    logic [EW-1:0] w_ext, h_ext, w_eff, h_eff;
    logic [EW-1:0] col_inc, row_inc;
    logic          last_col, last_row;

    // handshake: result register empties or drains, then the input stage moves up
    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc    = s_tvalid && s_tready;

    assign in_pix.red   = s_tdata[9:0];
    assign in_pix.green = s_tdata[19:10];
    assign in_pix.blue  = s_tdata[29:20];

    // dimensions saturate to 2..MAX_DIM
    assign w_ext = EW'(width_reg);
    assign h_ext = EW'(height_reg);
    assign w_eff = (w_ext < EW'(2)) ? EW'(2) : ((w_ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : w_ext);
    assign h_eff = (h_ext < EW'(2)) ? EW'(2) : ((h_ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : h_ext);

    // a counter at or past the last position wraps, also after a mid-frame resize
    assign col_inc  = EW'(col_reg) + EW'(1);
    assign row_inc  = EW'(row_reg) + EW'(1);
    assign last_col = (col_inc >= w_eff);
    assign last_row = (row_inc >= h_eff);

    // chroma on even columns: u on even rows, v on odd rows
    assign in_pos.chroma_valid = !col_reg[0];
    assign in_pos.chroma_plane = !col_reg[0] && row_reg[0];
    assign in_pos.frame_end    = last_col && last_row;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_acc) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[CW-1:0];
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= rgbyuv_pkg::DIM_W'(1920);
            height_reg   <= rgbyuv_pkg::DIM_W'(1080);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    rgbyuv_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                    rgbyuv_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (s_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_pix_reg <= in_pix;
            s1_pos_reg <= in_pos;
        end
        if (s1_adv && s1_valid_reg) begin
            m_res_reg <= csc_res;
        end
    end

    rgbyuv_csc u_csc (
        .pix (s1_pix_reg),
        .pos (s1_pos_reg),
        .res (csc_res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.chroma, m_res_reg.luma};
    assign m_tuser  = {m_res_reg.pos.chroma_plane, m_res_reg.pos.chroma_valid};
    assign m_tlast  = m_res_reg.pos.frame_end;

endmodule

[sv/rgbyuv_csc.sv]
// bt.601 studio-range color matrix with rounding shift, clamp and chroma select
// depends on rgbyuv_pkg; purely combinational, sits between two register stages

module rgbyuv_csc (
    input  rgbyuv_pkg::rgb_t pix,
    input  rgbyuv_pkg::pos_t pos,
    output rgbyuv_pkg::yuv_t res
);

    // level * 255 / 256, truncated
    function automatic logic [rgbyuv_pkg::LEVEL_W-1:0] scale(
        input logic [rgbyuv_pkg::LEVEL_W-1:0] lvl
    );
        logic [rgbyuv_pkg::LEVEL_W+7:0] tmp;
        tmp = {lvl, 8'd0} - {8'd0, lvl};
        return tmp[rgbyuv_pkg::LEVEL_W+7:8];
    endfunction

    // floor shift by 8, add offset, clamp to 0..255
    function automatic logic [rgbyuv_pkg::PIX_W-1:0] shift_clamp(
        input logic signed [19:0] acc,
        input logic signed [12:0] offset
    );
        logic signed [12:0] v;
        v = $signed({acc[19], acc[19:8]}) + offset;
        if (v < 13'sd0) begin
            return 8'd0;
        end else if (v > 13'sd255) begin
            return 8'd255;
        end else begin
            return v[7:0];
        end
    endfunction

    logic signed [19:0] r_s, g_s, b_s;
    logic signed [19:0] y_acc, u_acc, v_acc;
    logic [rgbyuv_pkg::PIX_W-1:0] y_byte, u_byte, v_byte;

    assign r_s = $signed({10'd0, scale(pix.red)});
    assign g_s = $signed({10'd0, scale(pix.green)});
    assign b_s = $signed({10'd0, scale(pix.blue)});

    assign y_acc = 20'sd66 * r_s + 20'sd129 * g_s + 20'sd25 * b_s + 20'sd128;
    assign u_acc = 20'sd112 * b_s - 20'sd38 * r_s - 20'sd74 * g_s + 20'sd128;
    assign v_acc = 20'sd112 * r_s - 20'sd94 * g_s - 20'sd18 * b_s + 20'sd128;

    assign y_byte = shift_clamp(y_acc, 13'sd16);
    assign u_byte = shift_clamp(u_acc, 13'sd128);
    assign v_byte = shift_clamp(v_acc, 13'sd128);

    always_comb begin
        res.luma = y_byte;
        res.pos  = pos;
        if (!pos.chroma_valid) begin
            res.chroma = '0;
        end else if (pos.chroma_plane) begin
            res.chroma = v_byte;
        end else begin
            res.chroma = u_byte;
        end
    end

endmodule
